// ===== rtl/crcfc_pkg.sv =====
package crcfc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;

  // Reflected CRC-32 constants.
  localparam logic [WordW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [WordW-1:0] CrcInit = 32'hFFFF_FFFF;

  // Reset value of the payload length limit (10 MiB).
  localparam logic [WordW-1:0] MaxLenReset = 32'(1024 * 1024 * 10);

  // Default depth of the queue between the parser and the checker.
  localparam int unsigned QueueDepthDef = 4;

  // Configuration address map: one 32-bit register per word.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned RegIdxW  = 1;
  localparam logic [RegIdxW-1:0] RegMaxLen = 1'b0;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_BADCRC = 2'd2,
    ST_BADLEN = 2'd3
  } status_e;

  // One classified item handed from the parser to the checker.
  typedef struct packed {
    logic              is_payload;
    logic              last;
    logic [ByteW-1:0]  data;
    logic [WordW-1:0]  expected;
  } q_entry_t;

  // One byte through the reflected CRC-32, LSB first.
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {{(WordW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = (c >> 1) ^ (CrcPoly & {WordW{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== rtl/crcfc_in_if.sv =====
interface crcfc_in_if;
  logic                       valid;
  logic                       ready;
  logic [crcfc_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/crcfc_out_if.sv =====
interface crcfc_out_if;
  logic                       valid;
  logic                       ready;
  logic [crcfc_pkg::ByteW-1:0] out_byte;
  logic                       byte_valid;
  logic                       frame_end;
  logic [1:0]                 frame_status;
  logic [crcfc_pkg::WordW-1:0] computed_crc;

  modport source (output valid, output out_byte, output byte_valid, output frame_end,
                  output frame_status, output computed_crc, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input frame_end,
                  input frame_status, input computed_crc, output ready);
endinterface

// ===== rtl/crcfc_queue.sv =====
module crcfc_queue #(
  parameter int unsigned Depth = crcfc_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crcfc_pkg::q_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output crcfc_pkg::q_entry_t pop_data_o,
  output logic                empty_o
);
  import crcfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");

endmodule

// ===== rtl/crcfc_front.sv =====
module crcfc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  crcfc_in_if.sink                      byte_i,
  input  logic [crcfc_pkg::WordW-1:0]   max_len_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output crcfc_pkg::q_entry_t           q_entry_o
);
  import crcfc_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN = 2'd0,
    PH_CHK = 2'd1,
    PH_PAY = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [1:0]       idx_q, idx_d;
  logic [WordW-1:0] len_q, len_d;
  logic [WordW-1:0] exp_q, exp_d;
  logic [WordW-1:0] left_q, left_d;
  logic             accept;
  logic             bad_len;

  // A byte is taken only when the queue has room for whatever it may produce.
  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && !q_full_i;
  assign bad_len      = (len_q == '0) || (len_q > max_len_i);

  always_comb begin
    phase_d              = phase_q;
    idx_d                = idx_q;
    len_d                = len_q;
    exp_d                = exp_q;
    left_d               = left_q;
    q_push_o             = 1'b0;
    q_entry_o.is_payload = 1'b1;
    q_entry_o.last       = (left_q <= WordW'(1));
    q_entry_o.data       = byte_i.data_byte;
    q_entry_o.expected   = exp_q;
    if (accept) begin
      unique case (phase_q)
        PH_PAY: begin
          q_push_o = 1'b1;
          left_d   = left_q - WordW'(1);
          if (q_entry_o.last) begin
            phase_d = PH_LEN;
            idx_d   = '0;
          end
        end
        PH_CHK: begin
          exp_d[{idx_q, 3'b000} +: ByteW] = byte_i.data_byte;
          if (idx_q == 2'd3) begin
            idx_d = '0;
            if (bad_len) begin
              phase_d              = PH_LEN;
              q_push_o             = 1'b1;
              q_entry_o.is_payload = 1'b0;
              q_entry_o.last       = 1'b1;
            end else begin
              left_d  = len_q;
              phase_d = PH_PAY;
            end
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        default: begin
          // Length field; the unused phase code also lands here.
          phase_d = PH_LEN;
          len_d[{idx_q, 3'b000} +: ByteW] = byte_i.data_byte;
          if (idx_q == 2'd3) begin
            idx_d   = '0;
            phase_d = PH_CHK;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      idx_q   <= '0;
      len_q   <= '0;
      exp_q   <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      exp_q   <= exp_d;
      left_q  <= left_d;
    end
  end

  a_left_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_badlen_from_chk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && !q_entry_o.is_payload) |-> (phase_q == PH_CHK && idx_q == 2'd3))
    else $error("bad-length report outside the end of the header");

  a_idx_idle_in_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> idx_q == 2'd0)
    else $error("header index not cleared during payload");

endmodule

// ===== rtl/crcfc_back.sv =====
module crcfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  crcfc_pkg::q_entry_t q_entry_i,
  output logic                q_pop_o,
  crcfc_out_if.source         result_o
);
  import crcfc_pkg::*;

  logic [WordW-1:0] crc_q, crc_d;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             byte_valid_q;
  logic             frame_end_q;
  status_e          status_q, status_d;
  logic [WordW-1:0] crc_out_q, crc_out_d;
  logic [WordW-1:0] crc_next;
  logic [WordW-1:0] crc_fin;

  // The output register frees when empty or when its item is taken.
  assign q_pop_o  = !q_empty_i && (!out_valid_q || result_o.ready);
  assign crc_next = crc_byte(crc_q, q_entry_i.data);
  assign crc_fin  = ~crc_next;

  always_comb begin
    crc_d     = crc_q;
    status_d  = ST_BUSY;
    crc_out_d = '0;
    if (!q_entry_i.is_payload) begin
      status_d = ST_BADLEN;
    end else if (q_entry_i.last) begin
      crc_d     = CrcInit;
      crc_out_d = crc_fin;
      status_d  = (crc_fin == q_entry_i.expected) ? ST_GOOD : ST_BADCRC;
    end else begin
      crc_d = crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      crc_q       <= crc_d;
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_byte_q   <= q_entry_i.is_payload ? q_entry_i.data : '0;
      byte_valid_q <= q_entry_i.is_payload;
      frame_end_q  <= q_entry_i.last;
      status_q     <= status_d;
      crc_out_q    <= crc_out_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.out_byte     = out_byte_q;
  assign result_o.byte_valid   = byte_valid_q;
  assign result_o.frame_end    = frame_end_q;
  assign result_o.frame_status = status_q;
  assign result_o.computed_crc = crc_out_q;

  a_crc_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_entry_i.last) |=> crc_q == CrcInit)
    else $error("CRC not reinitialized after frame end");

  a_badlen_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !q_entry_i.is_payload) |=>
      (status_q == ST_BADLEN && !byte_valid_q && frame_end_q && crc_out_q == '0))
    else $error("malformed bad-length result");

  a_busy_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_BUSY) |-> (!frame_end_q && crc_out_q == '0))
    else $error("in-progress result carries end or CRC");

endmodule

// ===== rtl/length_crc32_frame_checker_core.sv =====
// A payload byte taken by the parser is queued, then popped into the output register,
// where its result is offered. Throughput: one byte per cycle while the queue is not
// full; the CRC stage folds one byte per cycle while the output register is free.
// Header bytes give a result only when the length check fails; the queue absorbs stalls.
// Reset (rst_ni low, asynchronous): parser waits for a length field, CRC is all ones,
// the queue and output register are empty, and the length limit returns to 10 MiB.
module length_crc32_frame_checker_core #(
  parameter int unsigned QueueDepth = crcfc_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  crcfc_in_if.sink                          byte_i,
  crcfc_out_if.source                       result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [crcfc_pkg::ApbAddrW-1:0]    paddr,
  input  logic [crcfc_pkg::WordW-1:0]       pwdata,
  output logic [crcfc_pkg::WordW-1:0]       prdata,
  output logic                              pready
);
  import crcfc_pkg::*;

  // The only configuration register is the payload length limit. A write
  // lands in the access phase; the parser samples the limit when it checks
  // the length at the end of each header, so a frame already in its
  // payload keeps running under the limit it was checked against.
  logic [WordW-1:0]   max_len_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign reg_wr  = psel && penable && pwrite && (reg_idx == RegMaxLen);
  assign prdata  = (reg_idx == RegMaxLen) ? max_len_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (reg_wr) begin
      max_len_q <= pwdata;
    end
  end

  // The front end parses the header and tags every payload byte with its
  // last-byte flag and the expected CRC; a header that fails the length
  // check becomes a single bad-length item. No other header byte pushes anything.
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_push_data;
  q_entry_t q_pop_data;

  crcfc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .max_len_i (max_len_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_push_data)
  );

  // A short queue lets the parser keep taking bytes while the consumer stalls.
  crcfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // The back end runs the CRC, forms the frame status on the last byte or a bad-length item
  // and holds each result in an output register until the consumer takes it.
  crcfc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_entry_i (q_pop_data),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

endmodule

// ===== tb/length_crc32_frame_checker_core_tb.sv =====
module length_crc32_frame_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfc_pkg::*;

  // Each side idles in about this many cycles out of a hundred.
  localparam int unsigned IdlePct = 29;
  // Most header bytes give no result, so after the last result the parser may still be
  // busy with a few bytes. This many cycles cover the queue and output register with margin.
  localparam int unsigned SettleCycles = 4;
  // The receiver holds off once, for a long stretch, after this many results.
  localparam int unsigned HoldAt = 60;
  localparam int unsigned HoldCycles = 150;
  // Window of cycles in which neither side idles at all.
  localparam int unsigned SteadyFrom = 1200;
  localparam int unsigned SteadyTo = 1800;
  localparam int unsigned BytesPerSweep = 210;

  localparam logic [ApbAddrW-1:0] LimitAddr = ApbAddrW'(4 * RegMaxLen);

  // Where the parser stands inside the current frame.
  typedef enum logic [1:0] {
    LEN_FIELD,
    CHECK_FIELD,
    PAYLOAD
  } parse_phase_e;

  // One result item, laid out in the order of the output channel's fields.
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             frame_end;
    status_e          frame_status;
    logic [WordW-1:0] computed_crc;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [WordW-1:0]    pwdata;
  logic [WordW-1:0]    prdata;
  logic                pready;

  crcfc_in_if  bytes_in ();
  crcfc_out_if results_out ();

  length_crc32_frame_checker_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (bytes_in),
    .result_o (results_out),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk_i = ~clk_i;

  // Bytes still to be offered to the block, and the results the frame tracker
  // expects from the bytes already taken, oldest first.
  logic [ByteW-1:0] stream_bytes [$];
  frame_result_t    pending_results [$];

  int unsigned bytes_queued = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_no = 0;
  logic        steady;

  // Shadow of the frame parser: the same state the block keeps, at its widths.
  parse_phase_e     parse_phase = LEN_FIELD;
  logic [1:0]       hdr_idx = '0;
  logic [WordW-1:0] len_word = '0;
  logic [WordW-1:0] check_word = '0;
  logic [WordW-1:0] crc_run = CrcInit;
  logic [WordW-1:0] bytes_left = '0;
  logic [WordW-1:0] len_limit = MaxLenReset;

  always @(posedge clk_i) cycle_no <= cycle_no + 1;
  assign steady = (cycle_no >= SteadyFrom) && (cycle_no < SteadyTo);

  // Reflected CRC-32, one byte, least significant bit first.
  function automatic logic [WordW-1:0] crc32_fold(input logic [WordW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
    logic [WordW-1:0] r;
    r = crc ^ {{(WordW-ByteW){1'b0}}, b};
    repeat (ByteW) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  // Advances the shadow parser by one accepted byte and records the result it
  // causes, if any. Header bytes cause none, except that the fourth byte of the check
  // field causes a bad-length report when the length is zero or over the limit.
  function automatic void track_byte(input logic [ByteW-1:0] b);
    frame_result_t    r;
    logic [WordW-1:0] fin;
    r = '0;
    case (parse_phase)
      PAYLOAD: begin
        crc_run = crc32_fold(crc_run, b);
        if (bytes_left != 0) bytes_left--;
        r.out_byte = b;
        r.byte_valid = 1'b1;
        if (bytes_left == 0) begin
          fin = ~crc_run;
          r.frame_end = 1'b1;
          r.computed_crc = fin;
          if (fin == check_word) r.frame_status = ST_GOOD;
          else r.frame_status = ST_BADCRC;
          parse_phase = LEN_FIELD;
          hdr_idx = '0;
          crc_run = CrcInit;
        end else begin
          r.frame_status = ST_BUSY;
        end
        pending_results.push_back(r);
      end
      CHECK_FIELD: begin
        check_word[hdr_idx*8 +: 8] = b;
        if (hdr_idx == 2'd3) begin
          hdr_idx = '0;
          if (len_word == 0 || len_word > len_limit) begin
            parse_phase = LEN_FIELD;
            r.frame_end = 1'b1;
            r.frame_status = ST_BADLEN;
            pending_results.push_back(r);
          end else begin
            bytes_left = len_word;
            crc_run = CrcInit;
            parse_phase = PAYLOAD;
          end
        end else begin
          hdr_idx++;
        end
      end
      default: begin
        // The unused phase code falls back to reading the length field.
        parse_phase = LEN_FIELD;
        len_word[hdr_idx*8 +: 8] = b;
        if (hdr_idx == 2'd3) begin
          hdr_idx = '0;
          parse_phase = CHECK_FIELD;
        end else begin
          hdr_idx++;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: result %0d %s expected 0x%0h, got 0x%0h",
               $time, results_seen, what, want, got);
    end
  endfunction

  // Sender. The byte on the channel stays in the queue until it is taken; the
  // frame tracker sees it at the edge where the handshake completes.
  always @(posedge clk_i) begin : drive_bytes
    logic offer;
    if (!rst_ni) begin
      bytes_in.valid <= 1'b0;
    end else begin
      offer = bytes_in.valid;
      if (bytes_in.valid && bytes_in.ready) begin
        track_byte(bytes_in.data_byte);
        void'(stream_bytes.pop_front());
        offer = 1'b0;
      end
      if (!offer && stream_bytes.size() != 0 &&
          (steady || $urandom_range(0, 99) >= IdlePct)) begin
        bytes_in.data_byte <= stream_bytes[0];
        offer = 1'b1;
      end
      bytes_in.valid <= offer;
    end
  end

  // Receiver. Every accepted result is matched against the oldest expectation.
  // Once, after a few dozen results, ready stays low for a long stretch so that
  // the internal queue fills and the block has to stall its input.
  always @(posedge clk_i) begin : watch_results
    frame_result_t got;
    frame_result_t want;
    logic          take;
    if (!rst_ni) begin
      results_out.ready <= 1'b0;
    end else begin
      if (results_out.valid && results_out.ready) begin
        got = {results_out.out_byte, results_out.byte_valid, results_out.frame_end,
               results_out.frame_status, results_out.computed_crc};
        results_seen++;
        if (results_seen == HoldAt) hold_left = HoldCycles;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: result %0d arrived with none expected: %p",
                   $time, results_seen, got);
        end else begin
          want = pending_results.pop_front();
          check_field("out_byte", WordW'(want.out_byte), WordW'(got.out_byte));
          check_field("byte_valid", WordW'(want.byte_valid), WordW'(got.byte_valid));
          check_field("frame_end", WordW'(want.frame_end), WordW'(got.frame_end));
          check_field("frame_status", WordW'(want.frame_status),
                      WordW'(got.frame_status));
          check_field("computed_crc", want.computed_crc, got.computed_crc);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        take = steady || ($urandom_range(0, 99) >= IdlePct);
      end
      results_out.ready <= take;
    end
  end

  function automatic void queue_byte(input logic [ByteW-1:0] b);
    stream_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // Header fields go out least significant byte first.
  function automatic void queue_word(input logic [WordW-1:0] w);
    for (int i = 0; i < 4; i++) queue_byte(w[i*8 +: 8]);
  endfunction

  // A whole frame with random payload; a spoiled frame carries a check value
  // with one bit flipped, so it must end with a CRC mismatch.
  function automatic void queue_frame(input int unsigned len, input bit spoil);
    logic [ByteW-1:0] body [$];
    logic [WordW-1:0] c;
    c = CrcInit;
    for (int i = 0; i < len; i++) begin
      body.push_back(ByteW'($urandom_range(0, 255)));
      c = crc32_fold(c, body[i]);
    end
    c = ~c;
    if (spoil) c ^= 32'h1 << $urandom_range(0, 31);
    queue_word(len);
    queue_word(c);
    foreach (body[i]) queue_byte(body[i]);
  endfunction

  // A length that the current limit rejects: zero, just above the limit, all
  // ones, or anywhere in between.
  function automatic logic [WordW-1:0] bad_length(input logic [WordW-1:0] lim);
    if (lim == '1) return '0;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return lim + 1;
      2: return '1;
      default: return lim + 1 + ($urandom % (32'hFFFF_FFFF - lim));
    endcase
  endfunction

  // Waits until every byte has been taken and every expected result has come,
  // then lets the parser finish any header bytes that give no result.
  task automatic wait_drained();
    while (stream_bytes.size() != 0 || bytes_in.valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the length limit over the configuration port and reads it back.
  // The shadow limit changes at the edge where the write takes effect.
  task automatic write_limit(input logic [WordW-1:0] v);
    logic [WordW-1:0] seen;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    len_limit = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (seen !== v) begin
      errors++;
      $display("%0t ns: limit read back expected 0x%0h, got 0x%0h", $time, v, seen);
    end
  endtask

  initial begin : run_stimulus
    logic [ByteW-1:0] body [20];
    logic [WordW-1:0] crc_acc;
    logic [WordW-1:0] sweep [6];
    int unsigned      roll;
    int unsigned      cap;
    int unsigned      target;

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bytes_in.valid = 1'b0;
    bytes_in.data_byte = '0;
    results_out.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset limit: a one-byte good frame with an all-zero
    // payload, a two-byte frame with a wrong check value, a zero length, an
    // all-ones length, and a length just above the reset limit.
    queue_word(32'd1);
    queue_word(~crc32_fold(CrcInit, 8'h00));
    queue_byte(8'h00);
    queue_word(32'd2);
    queue_word(~crc32_fold(crc32_fold(CrcInit, 8'hFF), 8'h80) ^ 32'h8000_0000);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_word(32'd0);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'd0);
    queue_word(MaxLenReset + 1);
    queue_word($urandom);
    wait_drained();

    // Limit change in the middle of a payload: the frame already past its
    // header must finish normally even though its length now exceeds the limit.
    // After that a length just above the new limit is rejected and a length
    // equal to it is accepted.
    write_limit(32'd20);
    crc_acc = CrcInit;
    foreach (body[i]) begin
      body[i] = ByteW'($urandom_range(0, 255));
      crc_acc = crc32_fold(crc_acc, body[i]);
    end
    queue_word(32'd20);
    queue_word(~crc_acc);
    for (int i = 0; i < 8; i++) queue_byte(body[i]);
    wait_drained();
    write_limit(32'd3);
    for (int i = 8; i < 20; i++) queue_byte(body[i]);
    queue_word(32'd4);
    queue_word($urandom);
    queue_frame(3, 1'b0);
    wait_drained();

    // Random part, swept over several limits: the reset value, the smallest
    // nonzero limit, zero (every length rejected), all ones, a small random
    // limit and a large random one. Most items belong to well-formed frames,
    // about a third of them with a spoiled check value; the rest are headers
    // with rejected lengths. Each sweep ends with the sender paused until every
    // expected result has come.
    sweep = '{MaxLenReset, 32'd1, 32'd0, 32'hFFFF_FFFF,
              32'($urandom_range(2, 40)), $urandom | 32'h0001_0000};
    foreach (sweep[p]) begin
      write_limit(sweep[p]);
      target = bytes_queued + BytesPerSweep;
      while (bytes_queued < target) begin
        roll = $urandom_range(0, 99);
        cap = (len_limit < 24) ? len_limit : 24;
        if ($urandom_range(0, 19) == 0) cap = (len_limit < 96) ? len_limit : 96;
        if (roll < 80 && cap != 0) begin
          queue_frame($urandom_range(1, cap), roll >= 56);
        end else begin
          queue_word(bad_length(len_limit));
          queue_word($urandom);
        end
      end
      wait_drained();
    end

    // Truncated stream: an all-ones length under an all-ones limit is accepted,
    // and every byte after it is payload that never reaches the frame end.
    write_limit(32'hFFFF_FFFF);
    queue_word(32'hFFFF_FFFF);
    queue_word($urandom);
    repeat (40) queue_byte(ByteW'($urandom_range(0, 255)));
    wait_drained();

    if (errors == 0) begin
      $display("** length_crc32_frame_checker_core: PASSED **");
    end else begin
      $display("** length_crc32_frame_checker_core: FAILED **");
    end
    $finish;
  end

  // A correct run ends long before this bound.
  initial begin : run_timeout
    #400_000;
    $display("** length_crc32_frame_checker_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/crcfc_pkg.sv
rtl/crcfc_in_if.sv
rtl/crcfc_out_if.sv
rtl/crcfc_queue.sv
rtl/crcfc_front.sv
rtl/crcfc_back.sv
rtl/length_crc32_frame_checker_core.sv
tb/length_crc32_frame_checker_core_tb.sv
